[rtl/segment_rectangle_intersect_top_macros.svh]
// Assertion macros for the segment/rectangle intersection block.
// Included by the top level; no other dependencies.
`ifndef SEGMENT_RECTANGLE_INTERSECT_TOP_MACROS_SVH
`define SEGMENT_RECTANGLE_INTERSECT_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define SRI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, disabled during reset.
`define SRI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SRI_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define SRI_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

[rtl/sri_pkg.sv]
// Shared constants and compare functions for the segment/rectangle test.
// No dependencies.
package sri_pkg;

   localparam int COORD_WIDTH_DEF = 16;

   // Edge order, also the bit order of the edge mask.
   localparam int NUM_EDGES   = 4;
   localparam int EDGE_TOP    = 0;
   localparam int EDGE_RIGHT  = 1;
   localparam int EDGE_BOTTOM = 2;
   localparam int EDGE_LEFT   = 3;

   // Product slots. dx/dy: segment direction; ox*/oy*: segment start minus
   // rectangle left/right x or top/bottom y; wr: right - left; hb: bottom - top.
   localparam int NUM_PROD  = 10;
   localparam int P_DX_OYT  = 0;
   localparam int P_DX_OYB  = 1;
   localparam int P_DY_OXL  = 2;
   localparam int P_DY_OXR  = 3;
   localparam int P_WR_DY   = 4;
   localparam int P_HB_DX   = 5;
   localparam int P_WR_OYT  = 6;
   localparam int P_WR_OYB  = 7;
   localparam int P_HB_OXR  = 8;
   localparam int P_HB_OXL  = 9;

   // Widest product sum at the top of the coordinate range.
   localparam int WIDE_W = 64;

   // True when num/den lies in [0,1]; den is known nonzero.
   function automatic logic ratio_in_unit(input logic signed [WIDE_W-1:0] num,
                                          input logic signed [WIDE_W-1:0] den);
      logic num_nonneg;
      logic num_nonpos;
      num_nonneg = !num[WIDE_W-1];
      num_nonpos = num[WIDE_W-1] || (num == WIDE_W'(0));
      if (!den[WIDE_W-1]) begin
         ratio_in_unit = num_nonneg && (num <= den);
      end else begin
         ratio_in_unit = num_nonpos && (num >= den);
      end
   endfunction

   // Edge hit: nonparallel, both parameters in [0,1], not both zero.
   function automatic logic edge_cross(input logic signed [WIDE_W-1:0] na,
                                       input logic signed [WIDE_W-1:0] nb,
                                       input logic signed [WIDE_W-1:0] den);
      logic den_nz;
      logic both_zero;
      den_nz    = (den != WIDE_W'(0));
      both_zero = (na == WIDE_W'(0)) && (nb == WIDE_W'(0));
      edge_cross = den_nz && ratio_in_unit(na, den) && ratio_in_unit(nb, den)
                   && !both_zero;
   endfunction

endpackage

[rtl/sri_mul_stage.sv]
// Input register, coordinate differences and the product register.
// Depends on sri_pkg.
module sri_mul_stage import sri_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   localparam int PW = 2 * COORD_WIDTH + 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [COORD_WIDTH-1:0] seg_start_x,
   input  logic signed [COORD_WIDTH-1:0] seg_start_y,
   input  logic signed [COORD_WIDTH-1:0] seg_end_x,
   input  logic signed [COORD_WIDTH-1:0] seg_end_y,
   input  logic signed [COORD_WIDTH-1:0] rect_left,
   input  logic signed [COORD_WIDTH-1:0] rect_top,
   input  logic signed [COORD_WIDTH-1:0] rect_right,
   input  logic signed [COORD_WIDTH-1:0] rect_bottom,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [PW-1:0]          prod [NUM_PROD]
);

   localparam int DW = COORD_WIDTH + 1;

   logic                          s1_valid_ff, s1_valid_in, s1_ready;
   logic                          s2_valid_ff, s2_valid_in, s2_ready;
   logic signed [COORD_WIDTH-1:0] sx_ff, sy_ff, ex_ff, ey_ff;
   logic signed [COORD_WIDTH-1:0] l_ff, t_ff, r_ff, b_ff;
   logic signed [DW-1:0]          dx, dy, oxl, oxr, oyt, oyb, wr, hb;
   logic signed [PW-1:0]          prod_ff [NUM_PROD];
   logic signed [PW-1:0]          prod_in [NUM_PROD];

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   assign s1_valid_in = s1_ready ? in_valid : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && s1_ready) begin
         sx_ff <= seg_start_x;
         sy_ff <= seg_start_y;
         ex_ff <= seg_end_x;
         ey_ff <= seg_end_y;
         l_ff  <= rect_left;
         t_ff  <= rect_top;
         r_ff  <= rect_right;
         b_ff  <= rect_bottom;
      end
   end

   // Differences are exact one bit wider than the coordinates.
   always_comb begin
      dx  = DW'(ex_ff) - DW'(sx_ff);
      dy  = DW'(ey_ff) - DW'(sy_ff);
      oxl = DW'(sx_ff) - DW'(l_ff);
      oxr = DW'(sx_ff) - DW'(r_ff);
      oyt = DW'(sy_ff) - DW'(t_ff);
      oyb = DW'(sy_ff) - DW'(b_ff);
      wr  = DW'(r_ff)  - DW'(l_ff);
      hb  = DW'(b_ff)  - DW'(t_ff);
   end

   always_comb begin
      prod_in[P_DX_OYT] = PW'(dx) * PW'(oyt);
      prod_in[P_DX_OYB] = PW'(dx) * PW'(oyb);
      prod_in[P_DY_OXL] = PW'(dy) * PW'(oxl);
      prod_in[P_DY_OXR] = PW'(dy) * PW'(oxr);
      prod_in[P_WR_DY]  = PW'(wr) * PW'(dy);
      prod_in[P_HB_DX]  = PW'(hb) * PW'(dx);
      prod_in[P_WR_OYT] = PW'(wr) * PW'(oyt);
      prod_in[P_WR_OYB] = PW'(wr) * PW'(oyb);
      prod_in[P_HB_OXR] = PW'(hb) * PW'(oxr);
      prod_in[P_HB_OXL] = PW'(hb) * PW'(oxl);
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s2_ready) begin
         prod_ff <= prod_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign prod      = prod_ff;

endmodule

[rtl/sri_edge_test.sv]
// Per-edge numerators, denominators and range tests, plus the result register.
// Depends on sri_pkg.
module sri_edge_test import sri_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   localparam int PW = 2 * COORD_WIDTH + 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic signed [PW-1:0] prod [NUM_PROD],
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [NUM_EDGES-1:0] edge_mask
);

   logic                 valid_ff, valid_in;
   logic [NUM_EDGES-1:0] mask_ff, mask_in;
   logic signed [PW-1:0] den [NUM_EDGES];
   logic signed [PW-1:0] na  [NUM_EDGES];
   logic signed [PW-1:0] nb  [NUM_EDGES];

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Axis-aligned edges leave one product per denominator and numerator a.
   always_comb begin
      den[EDGE_TOP]    = -prod[P_WR_DY];
      den[EDGE_RIGHT]  =  prod[P_HB_DX];
      den[EDGE_BOTTOM] =  prod[P_WR_DY];
      den[EDGE_LEFT]   = -prod[P_HB_DX];

      na[EDGE_TOP]     =  prod[P_WR_OYT];
      na[EDGE_RIGHT]   = -prod[P_HB_OXR];
      na[EDGE_BOTTOM]  = -prod[P_WR_OYB];
      na[EDGE_LEFT]    =  prod[P_HB_OXL];

      nb[EDGE_TOP]     = prod[P_DX_OYT] - prod[P_DY_OXL];
      nb[EDGE_RIGHT]   = prod[P_DX_OYT] - prod[P_DY_OXR];
      nb[EDGE_BOTTOM]  = prod[P_DX_OYB] - prod[P_DY_OXR];
      nb[EDGE_LEFT]    = prod[P_DX_OYB] - prod[P_DY_OXL];

      for (int e = 0; e < NUM_EDGES; e++) begin
         mask_in[e] = edge_cross(WIDE_W'(na[e]), WIDE_W'(nb[e]), WIDE_W'(den[e]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         mask_ff <= mask_in;
      end
   end

   assign out_valid = valid_ff;
   assign edge_mask = mask_ff;

endmodule

[rtl/segment_rectangle_intersect_top.sv]
// Top level of the segment versus axis-aligned rectangle intersection test.
// Depends on sri_pkg, sri_mul_stage, sri_edge_test and the assertion macros.
//
//   Channel  Dir  Handshake              Carries
//   req_*    in   req_valid / req_ready  segment end points, rectangle bounds
//   rsp_*    out  rsp_valid / rsp_ready  hit flag, per-edge hit mask
//
// One request per cycle sustained while rsp_ready is high. Each request
// loads the input register at the edge that accepts it, then moves on to
// the product register and then to the result register that drives rsp_*.
// The product stage holds all ten signed multiplies, so it sets the clock.
// Reset is synchronous and empties all three stages; data registers keep
// their contents. A stalled response holds only the stages behind it: bubbles
// ahead fill while rsp_ready is low, so req_ready drops only when full.
`include "segment_rectangle_intersect_top_macros.svh"

module segment_rectangle_intersect_top import sri_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_seg_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_seg_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_seg_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_seg_end_y,
   input  logic signed [COORD_WIDTH-1:0] req_rect_left,
   input  logic signed [COORD_WIDTH-1:0] req_rect_top,
   input  logic signed [COORD_WIDTH-1:0] req_rect_right,
   input  logic signed [COORD_WIDTH-1:0] req_rect_bottom,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit,
   output logic [NUM_EDGES-1:0]          rsp_edge_hits
);

   localparam int PW = 2 * COORD_WIDTH + 2;

   // Products handed from the multiply stage to the edge tests.
   logic                 mid_valid;
   logic                 mid_ready;
   logic signed [PW-1:0] mid_prod [NUM_PROD];
   logic [NUM_EDGES-1:0] edge_mask;

   sri_mul_stage #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_mul (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .seg_start_x (req_seg_start_x),
      .seg_start_y (req_seg_start_y),
      .seg_end_x   (req_seg_end_x),
      .seg_end_y   (req_seg_end_y),
      .rect_left   (req_rect_left),
      .rect_top    (req_rect_top),
      .rect_right  (req_rect_right),
      .rect_bottom (req_rect_bottom),
      .out_valid   (mid_valid),
      .out_ready   (mid_ready),
      .prod        (mid_prod)
   );

   sri_edge_test #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_edge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .prod      (mid_prod),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .edge_mask (edge_mask)
   );

   // Any edge crossed counts as a hit.
   assign rsp_edge_hits = edge_mask;
   assign rsp_hit       = |edge_mask;

   // A stalled response must hold back the product stage.
   `SRI_ASSERT_NOW(a_stall_blocks_mid, clock, reset, rsp_valid && !rsp_ready, !mid_ready, "product stage advanced into a stalled response")
   // An empty result register never blocks the product stage.
   `SRI_ASSERT_NOW(a_empty_takes_mid, clock, reset, !rsp_valid, mid_ready, "empty result register refused products")
   // Products taken into the result stage show up as a response next cycle.
   `SRI_ASSERT_NEXT(a_mid_to_rsp, clock, reset, mid_valid && mid_ready, rsp_valid, "accepted products produced no response")

endmodule
